[src/bafd_pkg.sv]
// shared constants, widths and controller/datapath interface types for the box filter
// no dependencies
package bafd_pkg;

  localparam int unsigned MAX_RADIUS     = 8;
  localparam int unsigned MAX_LINE_BYTES = 2048;
  localparam int unsigned MAX_CHANNELS   = 4;
  localparam int unsigned STORE_ROWS     = 2 * MAX_RADIUS + 1;
  localparam int unsigned LS_DEPTH       = STORE_ROWS * MAX_LINE_BYTES;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned RAD_W    = 4;
  localparam int unsigned EPP_W    = 3;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned COL_W    = 13;
  localparam int unsigned SUM_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  localparam int unsigned X_W    = $clog2(MAX_LINE_BYTES);
  localparam int unsigned SLOT_W = $clog2(STORE_ROWS + 1);
  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned LS_AW  = $clog2(LS_DEPTH);
  localparam int unsigned NEPP_W = $clog2(STORE_ROWS * MAX_CHANNELS + 1);
  localparam int unsigned CMP_W  = (X_W > NEPP_W) ? X_W + 1 : NEPP_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE   = 2'd2;

  // ceil(2^RECIP_SHIFT / (2r+1)^2), exact floor for any window sum
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP [MAX_RADIUS+1] = '{
    29'd268435456, 29'd29826162, 29'd10737419, 29'd5478275, 29'd3314018,
    29'd2218475, 29'd1588376, 29'd1193047, 29'd928843
  };

  typedef struct packed {
    logic capture;  // take the input transaction, issue memory reads
    logic calc;     // update sums, write memories, advance position
    logic load;     // scale window sum into the output register
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
  } status_t;

endpackage

[src/bafd_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module bafd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/bafd_ctrl.sv]
// sequencing state machine: accept, sum update, scale and output load
// depends on bafd_pkg
module bafd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bafd_pkg::status_t st_i,
  output bafd_pkg::cmd_t    cmd_o
);
  import bafd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        if (!st_i.emit) begin
          state_d = ST_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/bafd_datapath.sv]
// config registers, position counters, line store, column sums, running sums, scaling
// depends on bafd_pkg and bafd_ram
module bafd_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bafd_pkg::cmd_t                    cmd_i,
  output bafd_pkg::status_t                 st_o,
  input  logic [bafd_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                              frame_start_i,
  input  logic                              cfg_write_i,
  input  logic [bafd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bafd_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [bafd_pkg::SAMPLE_W-1:0]     average_o,
  output logic                              row_end_o
);
  import bafd_pkg::*;

  // configuration
  logic [RAD_W-1:0] radius_q;
  logic [EPP_W-1:0] epp_q;
  logic [LEN_W-1:0] len_q;
  logic [RAD_W-1:0] r_eff;
  logic [EPP_W-1:0] epp_eff;
  logic [LEN_W-1:0] len_eff;
  logic [SLOT_W-1:0] n_win;
  logic [NEPP_W-1:0] n_epp, two_r_epp;
  logic restart;

  assign r_eff   = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
  assign epp_eff = (epp_q == '0) ? EPP_W'(1) :
                   (epp_q > EPP_W'(MAX_CHANNELS)) ? EPP_W'(MAX_CHANNELS) : epp_q;
  assign len_eff = (len_q == '0) ? LEN_W'(1) :
                   (len_q > LEN_W'(MAX_LINE_BYTES)) ? LEN_W'(MAX_LINE_BYTES) : len_q;
  assign n_win     = SLOT_W'({r_eff, 1'b1});
  assign n_epp     = NEPP_W'(n_win) * NEPP_W'(epp_eff);
  assign two_r_epp = NEPP_W'({r_eff, 1'b0}) * NEPP_W'(epp_eff);
  assign restart   = cfg_write_i && (cfg_index_i == CFG_RADIUS || cfg_index_i == CFG_EPP ||
                                     cfg_index_i == CFG_LINE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RAD_W'(1);
      epp_q    <= EPP_W'(3);
      len_q    <= LEN_W'(MAX_LINE_BYTES);
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        CFG_EPP:    epp_q    <= cfg_data_i[EPP_W-1:0];
        CFG_LINE:   len_q    <= cfg_data_i[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  // stream position for the next transaction
  logic [X_W-1:0]    col_q;
  logic [ROW_W-1:0]  row_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CH_W-1:0]   chp_q;

  // position of the transaction in flight
  logic [X_W-1:0]      x_q, x_cur;
  logic [ROW_W-1:0]    y_q, y_cur;
  logic [SLOT_W-1:0]   s_q, s_cur;
  logic [CH_W-1:0]     ch_q, ch_cur;
  logic [SAMPLE_W-1:0] sample_q;

  assign x_cur  = frame_start_i ? '0 : col_q;
  assign y_cur  = frame_start_i ? '0 : row_q;
  assign s_cur  = frame_start_i ? '0 : slot_q;
  assign ch_cur = frame_start_i ? '0 : chp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x_q      <= x_cur;
      y_q      <= y_cur;
      s_q      <= s_cur;
      ch_q     <= ch_cur;
      sample_q <= sample_i;
    end
  end

  // memories
  logic [LS_AW-1:0]    ls_raddr, ls_waddr;
  logic [SAMPLE_W-1:0] ls_old;
  logic [COL_W-1:0]    col_here, col_back, v_new;
  logic [X_W-1:0]      back_addr;

  assign ls_raddr  = LS_AW'(s_cur) * LS_AW'(MAX_LINE_BYTES) + LS_AW'(x_cur);
  assign ls_waddr  = LS_AW'(s_q) * LS_AW'(MAX_LINE_BYTES) + LS_AW'(x_q);
  assign back_addr = x_cur - X_W'(n_epp);

  bafd_ram #(.Width(SAMPLE_W), .Depth(LS_DEPTH)) u_line_store (
    .clk_i, .we_i(cmd_i.calc), .waddr_i(ls_waddr), .wdata_i(sample_q),
    .re_i(cmd_i.capture), .raddr_i(ls_raddr), .rdata_o(ls_old)
  );

  // two copies of the column sums give two reads per transaction
  bafd_ram #(.Width(COL_W), .Depth(MAX_LINE_BYTES)) u_col_here (
    .clk_i, .we_i(cmd_i.calc), .waddr_i(x_q), .wdata_i(v_new),
    .re_i(cmd_i.capture), .raddr_i(x_cur), .rdata_o(col_here)
  );

  bafd_ram #(.Width(COL_W), .Depth(MAX_LINE_BYTES)) u_col_back (
    .clk_i, .we_i(cmd_i.calc), .waddr_i(x_q), .wdata_i(v_new),
    .re_i(cmd_i.capture), .raddr_i(back_addr), .rdata_o(col_back)
  );

  // sum update
  logic [SUM_W-1:0] cws_q [MAX_CHANNELS];
  logic [SUM_W-1:0] h_new, h_q;
  logic [CMP_W-1:0] x_ext;
  logic             emit_new, emit_q, rend_q;
  logic [RAD_W-1:0] r_q;

  assign x_ext = CMP_W'(x_q);

  always_comb begin
    v_new = (y_q == '0) ? COL_W'(sample_q) : col_here + COL_W'(sample_q);
    if (y_q >= ROW_W'(n_win)) begin
      v_new = v_new - COL_W'(ls_old);
    end
    h_new = (x_ext < CMP_W'(epp_eff)) ? SUM_W'(v_new) : cws_q[ch_q] + SUM_W'(v_new);
    if (x_ext >= CMP_W'(n_epp)) begin
      h_new = h_new - SUM_W'(col_back);
    end
  end

  assign emit_new = (y_q >= ROW_W'({r_eff, 1'b0})) && (x_ext >= CMP_W'(two_r_epp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        cws_q[i] <= '0;
      end
      emit_q <= 1'b0;
    end else if (cmd_i.calc) begin
      cws_q[ch_q] <= h_new;
      emit_q      <= emit_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      h_q    <= h_new;
      rend_q <= (CMP_W'(x_q) == CMP_W'(len_eff) - CMP_W'(1));
      r_q    <= r_eff;
    end
  end

  // position advance
  logic [CMP_W-1:0]  x_inc;
  logic [SLOT_W-1:0] s_inc;
  logic [CH_W-1:0]   ch_inc;

  assign x_inc  = CMP_W'(x_q) + CMP_W'(1);
  assign s_inc  = s_q + SLOT_W'(1);
  assign ch_inc = ch_q + CH_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      chp_q  <= '0;
    end else if (restart) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      chp_q  <= '0;
    end else if (cmd_i.calc) begin
      if (x_inc >= CMP_W'(len_eff)) begin
        col_q  <= '0;
        chp_q  <= '0;
        row_q  <= (y_q == '1) ? y_q : y_q + ROW_W'(1);
        slot_q <= (s_inc >= n_win) ? '0 : s_inc;
      end else begin
        col_q  <= x_inc[X_W-1:0];
        row_q  <= y_q;
        slot_q <= s_q;
        chp_q  <= (CMP_W'(ch_inc) >= CMP_W'(epp_eff)) ? '0 : ch_inc;
      end
    end
  end

  // scaling by the reciprocal of the window count, straight into the output register
  logic [SUM_W+RECIP_W-1:0] prod;
  logic                     out_valid_q;
  logic [SAMPLE_W-1:0]      avg_q;
  logic                     oend_q;

  assign prod = (SUM_W+RECIP_W)'(h_q) * (SUM_W+RECIP_W)'(RECIP[r_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      avg_q  <= prod[RECIP_SHIFT +: SAMPLE_W];
      oend_q <= rend_q;
    end
  end

  assign st_o.emit     = emit_q;
  assign st_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign average_o     = avg_q;
  assign row_end_o     = oend_q;

endmodule

[src/box_average_filter_2d_core.sv]
// top level of the 2-d box average filter
// depends on bafd_pkg, bafd_ctrl, bafd_datapath (and bafd_ram through it)
//
// Input channel: in_valid_i/in_ready_o carry one channel byte (sample_i) of a
// padded interleaved image in raster order; frame_start_i marks the first byte.
// Output channel: out_valid_o/out_ready_i carry average_o, the floor mean of
// the (2r+1) x (2r+1) same-channel window, and row_end_o on the last result of
// an output row. Bytes that do not close a complete window give no result.
// Config channel: cfg_valid_i/cfg_ready_o write radius (0), elems_per_pixel
// (1) or line_bytes (2); any listed write restarts the frame. Write only idle.
// Sequence: a byte is taken only once the one before has left its multiply
// step: accept with line store and column sum reads, then the registered-read
// sum update and the reciprocal multiply into the output register, which
// raises out_valid_o.
// The output register parts the channels: the next byte is taken while a
// result waits; if the receiver still stalls, that byte holds at its multiply
// step until the output register frees.
// Reset: registers go to radius 1, 3 bytes per pixel, 2048 byte lines and the
// position counters to zero; the memories need no clearing pass.
module box_average_filter_2d_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [bafd_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic                               frame_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [bafd_pkg::SAMPLE_W-1:0]      average_o,
  output logic                               row_end_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bafd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bafd_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import bafd_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  bafd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .st_i(st), .cmd_o(cmd)
  );

  bafd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .st_o(st), .sample_i, .frame_start_i,
    .cfg_write_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_ready_i, .out_valid_o, .average_o, .row_end_o
  );

  // an accepted transaction goes straight into the sum update
  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (cmd.calc && !in_ready_o))
    else $error("accepted transaction did not enter sum update");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // a load makes a result visible next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> out_valid_o)
    else $error("loaded result not presented");

endmodule

[bench/tb_box_average_filter_2d_core.sv]
// self-checking bench for box_average_filter_2d_core: a behavioral predictor of the
// windowed mean runs beside the block, fed with directed and random frames
// depends on bafd_pkg and the box_average_filter_2d_core rtl
module tb_box_average_filter_2d_core;
  import bafd_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                row_end;
  } mean_t;

  // index outside the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [SAMPLE_W-1:0]  sample_i = '0;
  logic                 frame_start_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [SAMPLE_W-1:0]  average_o;
  logic                 row_end_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  box_average_filter_2d_core u_dut (.*);

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  pix_store [LS_DEPTH];
  int          col_sum [MAX_LINE_BYTES];
  int          win_sum [MAX_CHANNELS];
  int          col_pos, row_pos, row_slot;
  int          cur_radius, cur_epp, cur_line;
  mean_t       expected_means [$];
  int          err_count;
  int          idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
  bit          want_hold;
  int          hold_left;

  task automatic report_mismatch(input string what, input int got, input int exp_v);
    $display("mismatch: %s got %0d expected %0d", what, got, exp_v);
    err_count++;
  endtask

  task automatic restart_frame();
    foreach (col_sum[i]) col_sum[i] = 0;
    foreach (win_sum[i]) win_sum[i] = 0;
    col_pos = 0;
    row_pos = 0;
    row_slot = 0;
  endtask

  task automatic predict_box_mean(input logic [7:0] s, input logic fs);
    int r, e, l, n, x, y, idx, old, v, h, ch;
    r = (cur_radius > MAX_RADIUS) ? MAX_RADIUS : cur_radius;
    e = (cur_epp == 0) ? 1 : ((cur_epp > MAX_CHANNELS) ? MAX_CHANNELS : cur_epp);
    l = (cur_line == 0) ? 1 : ((cur_line > MAX_LINE_BYTES) ? MAX_LINE_BYTES : cur_line);
    n = 2 * r + 1;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      row_slot = 0;
    end
    if (col_pos >= l) col_pos = 0;
    if (row_slot >= n) row_slot = 0;
    x = col_pos;
    y = row_pos;
    idx = row_slot * MAX_LINE_BYTES + x;
    old = int'(pix_store[idx]);
    pix_store[idx] = s;
    v = (y == 0) ? int'(s) : col_sum[x] + int'(s);
    if (y >= n) v -= old;
    v &= 'h1fff;
    col_sum[x] = v;
    ch = x % e;
    h = (x < e) ? v : win_sum[ch] + v;
    if (x >= n * e) h -= col_sum[x - n * e];
    h &= 'h1ffff;
    win_sum[ch] = h;
    if (y >= 2 * r && x >= 2 * r * e) begin
      expected_means.push_back('{average: 8'(h / (n * n)), row_end: (x == l - 1)});
    end
    col_pos = x + 1;
    if (col_pos >= l) begin
      col_pos = 0;
      if (row_pos < 'hffff) row_pos++;
      row_slot++;
      if (row_slot >= n) row_slot = 0;
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (want_hold) begin
      hold_left = 400;
      want_hold = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready_i <= ($urandom_range(99) >= 63);
    end else if (idle_mode == 3) begin
      out_ready_i <= ($urandom_range(99) >= 34);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result checker, sampled mid-cycle so the handshake is stable
  always @(negedge clk_i) begin
    mean_t exp_m;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_means.size() == 0) begin
        report_mismatch("unexpected result transaction, average", int'(average_o), -1);
      end else begin
        exp_m = expected_means.pop_front();
        if (average_o !== exp_m.average)
          report_mismatch("average", int'(average_o), int'(exp_m.average));
        if (row_end_o !== exp_m.row_end)
          report_mismatch("row_end", int'(row_end_o), int'(exp_m.row_end));
      end
    end
  end

  // called at a rising edge; leaves valid high after the transaction
  task automatic send_sample(input logic [7:0] s, input logic fs);
    int pct;
    pct = (idle_mode == 1) ? 63 : ((idle_mode == 3) ? 34 : 0);
    if (pct > 0 && $urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < pct);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    frame_start_i <= fs;
    do @(negedge clk_i); while (!in_ready_o);
    predict_box_mean(s, fs);
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_RADIUS: cur_radius = int'(d[3:0]);
      CFG_EPP:    cur_epp = int'(d[2:0]);
      CFG_LINE:   cur_line = int'(d[11:0]);
      default:    return;
    endcase
    restart_frame();
  endtask

  task automatic set_geometry(input int r, input int e, input int l);
    drain();
    write_reg(CFG_RADIUS, CFG_DAT_W'(r));
    write_reg(CFG_EPP, CFG_DAT_W'(e));
    write_reg(CFG_LINE, CFG_DAT_W'(l));
  endtask

  // random frame content, occasional stray or missing frame start
  task automatic run_frame(input int r, input int e, input int l, input int count,
                           input int mode);
    set_geometry(r, e, l);
    idle_mode = mode;
    for (int i = 0; i < count; i++) begin
      send_sample(8'($urandom_range(255)),
                  (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0));
    end
  endtask

  task automatic test_reset_geometry();
    // reset registers: 2048-byte rows never complete a window here
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b0);
    send_sample(8'h55, 1'b0);
    send_sample(8'haa, 1'b0);
    drain();
    write_reg(CFG_SPARE, 12'hfff);
  endtask

  task automatic test_unit_window();
    logic [7:0] vals [6] = '{8'd0, 8'd255, 8'h55, 8'haa, 8'd1, 8'd128};
    set_geometry(0, 0, 0);
    foreach (vals[i]) send_sample(vals[i], i[0]);
  endtask

  task automatic test_full_scale();
    set_geometry(1, 1, 3);
    for (int i = 0; i < 6; i++) send_sample(8'd255, i == 0);
  endtask

  task automatic test_short_rows();
    set_geometry(2, 2, 8);
    for (int i = 0; i < 8; i++) send_sample(8'd200, i == 0);
  endtask

  task automatic test_extremes();
    run_frame(15, 1, 18, 18 * 18, 3);
    run_frame(1, 7, 12, 96, 1);
    run_frame(0, 1, 4095, 40, 2);
  endtask

  task automatic test_random_geometry();
    int r, e, l;
    for (int k = 0; k < 6; k++) begin
      r = $urandom_range(3);
      e = $urandom_range(4, 1);
      l = 2 * r * e + 1 + $urandom_range(5);
      run_frame(r, e, l, l * (2 * r + 1 + $urandom_range(5, 2)), k % 4);
    end
  endtask

  task automatic test_output_backpressure();
    set_geometry(0, 2, 16);
    idle_mode = 0;
    want_hold = 1'b1;
    for (int i = 0; i < 60; i++) send_sample(8'($urandom_range(255)), i == 0);
  endtask

  initial begin
    err_count = 0;
    idle_mode = 0;
    want_hold = 1'b0;
    hold_left = 0;
    foreach (pix_store[i]) pix_store[i] = '0;
    cur_radius = 1;
    cur_epp = 3;
    cur_line = 2048;
    restart_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_unit_window();
    test_full_scale();
    test_short_rows();
    test_extremes();
    test_random_geometry();
    test_output_backpressure();
    drain();
    if (err_count == 0) begin
      $display("tb_box_average_filter_2d_core: clean");
    end else begin
      $display("tb_box_average_filter_2d_core: errors");
    end
    $finish;
  end

  initial begin
    #(12 * 1000000);
    $display("tb_box_average_filter_2d_core: errors");
    $finish;
  end

endmodule
